[src/tpa_pkg.sv]
package tpa_pkg;

    localparam int DEF_RING_DEPTH = 24;

    localparam int CMD_W     = 2;
    localparam int PERIOD_W  = 22;
    localparam int TIME_W    = 32;
    localparam int RPM_W     = 20;
    localparam int PPR_W     = 8;
    localparam int TIMEOUT_W = 31;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 4;
    localparam int DIV_W     = 32;
    localparam int DENOM_W   = PERIOD_W + PPR_W;

    localparam int MEAN_FLOOR_US = 100;
    localparam int US_PER_MINUTE = 60000000;

    localparam logic [PPR_W-1:0]     PPR_RESET     = PPR_W'(1);
    localparam logic [RPM_W-1:0]     LIMIT_RESET   = '0;
    localparam logic [RPM_W-1:0]     IDLE_RESET    = '0;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(2000000);

    typedef enum logic [CMD_W-1:0] {
        CMD_CAPTURE  = 2'd0,
        CMD_OVERFLOW = 2'd1,
        CMD_UPDATE   = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_PPR     = 2'd0,
        REG_LIMIT   = 2'd1,
        REG_IDLE    = 2'd2,
        REG_TIMEOUT = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPLY,
        S_SUM,
        S_DIV_MEAN,
        S_MUL,
        S_DIV_RPM_START,
        S_DIV_RPM,
        S_FINISH,
        S_EMIT
    } t_state;

    typedef enum logic {
        DIV_SEL_MEAN,
        DIV_SEL_RPM
    } t_div_sel;

    typedef struct packed {
        logic [PPR_W-1:0]     pulses_per_rev;
        logic [RPM_W-1:0]     rpm_limit;
        logic [RPM_W-1:0]     idle_rpm_min;
        logic [TIMEOUT_W-1:0] capture_timeout_us;
    } t_cfg;

    typedef struct packed {
        logic     latch;
        logic     capture;
        logic     overflow;
        logic     sum_start;
        logic     sum_run;
        logic     div_start;
        t_div_sel div_sel;
        logic     mul;
        logic     finish;
        logic     out_load;
    } t_ctl;

    typedef struct packed {
        t_cmd cmd;
        logic sum_done;
        logic div_done;
    } t_sts;

endpackage

[src/tpa_regs.sv]
module tpa_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpa_pkg::ADDR_W-1:0]    paddr,
    input  logic [tpa_pkg::DATA_W-1:0]    pwdata,
    output logic [tpa_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output tpa_pkg::t_cfg                 o_cfg
);
    import tpa_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulses_per_rev     <= PPR_RESET;
            r_cfg.rpm_limit          <= LIMIT_RESET;
            r_cfg.idle_rpm_min       <= IDLE_RESET;
            r_cfg.capture_timeout_us <= TIMEOUT_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_PPR:     r_cfg.pulses_per_rev     <= pwdata[PPR_W-1:0];
                REG_LIMIT:   r_cfg.rpm_limit          <= pwdata[RPM_W-1:0];
                REG_IDLE:    r_cfg.idle_rpm_min       <= pwdata[RPM_W-1:0];
                REG_TIMEOUT: r_cfg.capture_timeout_us <= pwdata[TIMEOUT_W-1:0];
                default:     r_cfg                    <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PPR:     prdata = DATA_W'(r_cfg.pulses_per_rev);
            REG_LIMIT:   prdata = DATA_W'(r_cfg.rpm_limit);
            REG_IDLE:    prdata = DATA_W'(r_cfg.idle_rpm_min);
            REG_TIMEOUT: prdata = DATA_W'(r_cfg.capture_timeout_us);
            default:     prdata = '0;
        endcase
    end

endmodule

[src/tpa_div.sv]
module tpa_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tpa_pkg::DIV_W-1:0]  i_dividend,
    input  logic [tpa_pkg::DIV_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [tpa_pkg::DIV_W-1:0]  o_quotient
);
    import tpa_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DIV_W:0]   n_trial;
    logic [DIV_W:0]   n_diff;
    logic             n_ge;

    // One restoring step per cycle, quotient bits shift in behind the dividend.
    always_comb begin
        n_trial = {r_rem, r_quo[DIV_W-1]};
        n_diff  = n_trial - {1'b0, r_div};
        n_ge    = (n_trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[DIV_W-1:0] : n_trial[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], n_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[src/tpa_datapath.sv]
module tpa_datapath #(
    parameter int RING_DEPTH = tpa_pkg::DEF_RING_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tpa_pkg::t_cfg                 i_cfg,
    input  tpa_pkg::t_ctl                 i_ctl,
    output tpa_pkg::t_sts                 o_sts,
    input  logic [tpa_pkg::CMD_W-1:0]     i_command,
    input  logic [tpa_pkg::PERIOD_W-1:0]  i_period_us,
    input  logic [tpa_pkg::TIME_W-1:0]    i_now_us,
    output logic [tpa_pkg::RPM_W-1:0]     o_speed_rpm,
    output logic                          o_over_limit,
    output logic                          o_engine_running
);
    import tpa_pkg::*;

    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SUM_W = PERIOD_W + CNT_W;

    logic [PERIOD_W-1:0] r_ring [RING_DEPTH];
    logic [PERIOD_W-1:0] r_rd_data;

    logic [CMD_W-1:0]    r_cmd;
    logic [PERIOD_W-1:0] r_period;
    logic [TIME_W-1:0]   r_now;
    logic [TIME_W-1:0]   r_last;
    logic [CNT_W-1:0]    r_count;
    logic [IDX_W-1:0]    r_slot;
    logic [RPM_W-1:0]    r_rpm;

    logic [CNT_W-1:0]    r_idx;
    logic                r_pend;
    logic [SUM_W-1:0]    r_acc;
    logic [PERIOD_W-1:0] r_mean;
    logic [DENOM_W-1:0]  r_denom;

    logic                w_more;
    logic [TIME_W-1:0]   w_elapsed;
    logic                w_recent;
    logic                w_rpm_ok;
    logic [DIV_W-1:0]    w_dividend;
    logic [DIV_W-1:0]    w_divisor;
    logic [DIV_W-1:0]    w_quo;
    logic                w_div_done;

    assign w_more    = (r_idx < r_count);
    assign w_elapsed = r_now - r_last;
    assign w_recent  = (w_elapsed < {1'b0, i_cfg.capture_timeout_us});

    // Zero count or zero pulses make the divider results meaningless; both end in rpm 0.
    assign w_rpm_ok = (r_count != '0) && (i_cfg.pulses_per_rev != '0)
                   && (r_mean > PERIOD_W'(MEAN_FLOOR_US)) && w_recent;

    always_comb begin
        if (i_ctl.div_sel == DIV_SEL_MEAN) begin
            w_dividend = DIV_W'(r_acc);
            w_divisor  = DIV_W'(r_count);
        end else begin
            w_dividend = DIV_W'(US_PER_MINUTE);
            w_divisor  = DIV_W'(r_denom);
        end
    end

    tpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_ring[r_slot] <= r_period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_run && w_more) begin
            r_rd_data <= r_ring[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd    <= i_command;
            r_period <= i_period_us;
            r_now    <= i_now_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_slot  <= '0;
            r_last  <= '0;
            r_rpm   <= '0;
        end else begin
            if (i_ctl.capture) begin
                if (r_count < CNT_W'(RING_DEPTH)) begin
                    r_count <= r_count + CNT_W'(1);
                end
                r_slot <= (r_slot == IDX_W'(RING_DEPTH - 1)) ? '0 : r_slot + IDX_W'(1);
                r_last <= r_now;
            end else if (i_ctl.overflow) begin
                r_count <= '0;
                r_slot  <= '0;
            end
            if (i_ctl.finish) begin
                r_rpm <= w_rpm_ok ? w_quo[RPM_W-1:0] : '0;
            end
        end
    end

    // Read address runs ahead of the accumulate; r_pend marks a registered read waiting to be added.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_idx  <= '0;
        end else if (i_ctl.sum_start) begin
            r_pend <= 1'b0;
            r_idx  <= '0;
        end else if (i_ctl.sum_run) begin
            r_pend <= w_more;
            if (w_more) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_start) begin
            r_acc <= '0;
        end else if (i_ctl.sum_run && r_pend) begin
            r_acc <= r_acc + SUM_W'(r_rd_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_mean  <= w_quo[PERIOD_W-1:0];
            r_denom <= w_quo[PERIOD_W-1:0] * i_cfg.pulses_per_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            o_speed_rpm      <= r_rpm;
            o_over_limit     <= (r_rpm > i_cfg.rpm_limit);
            o_engine_running <= w_recent && (r_rpm > i_cfg.idle_rpm_min);
        end
    end

    assign o_sts.cmd      = t_cmd'(r_cmd);
    assign o_sts.sum_done = !w_more && !r_pend;
    assign o_sts.div_done = w_div_done;

endmodule

[src/tpa_ctrl.sv]
module tpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  tpa_pkg::t_sts  i_sts,
    output tpa_pkg::t_ctl  o_ctl
);
    import tpa_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_ctl         = '0;
        o_ctl.div_sel = DIV_SEL_MEAN;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.latch = 1'b1;
                    n_state     = S_APPLY;
                end
            end
            S_APPLY: begin
                unique case (i_sts.cmd)
                    CMD_CAPTURE: begin
                        o_ctl.capture = 1'b1;
                        n_state       = S_EMIT;
                    end
                    CMD_OVERFLOW: begin
                        o_ctl.overflow = 1'b1;
                        n_state        = S_EMIT;
                    end
                    CMD_UPDATE: begin
                        o_ctl.sum_start = 1'b1;
                        n_state         = S_SUM;
                    end
                    default: n_state = S_EMIT;
                endcase
            end
            S_SUM: begin
                o_ctl.sum_run = 1'b1;
                if (i_sts.sum_done) begin
                    o_ctl.div_start = 1'b1;
                    o_ctl.div_sel   = DIV_SEL_MEAN;
                    n_state         = S_DIV_MEAN;
                end
            end
            S_DIV_MEAN: begin
                if (i_sts.div_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_ctl.mul = 1'b1;
                n_state   = S_DIV_RPM_START;
            end
            S_DIV_RPM_START: begin
                o_ctl.div_start = 1'b1;
                o_ctl.div_sel   = DIV_SEL_RPM;
                n_state         = S_DIV_RPM;
            end
            S_DIV_RPM: begin
                o_ctl.div_sel = DIV_SEL_RPM;
                if (i_sts.div_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_ctl.finish = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

[src/tachometer_period_averager.sv]
// Tachometer period averager. Each input item is a capture (store a pulse period in the
// ring and note its time), an overflow (empty the ring) or an update (recompute rpm from
// the mean stored period); every item returns one result item with the speed, the
// over-limit flag and the running flag as they stand after that item. Items are handled
// one at a time: a capture, an overflow or an unused command is latched, applied and then
// loaded into the output register; an update is latched, then sums the stored periods
// with the one-entry-per-cycle ring read and makes two passes through the shared
// serial divider (mean, then 60000000 / (mean * pulses)) before its result is loaded.
// A result waiting in the output register does not stop the next item from being
// accepted.
module tachometer_period_averager #(
    parameter int RING_DEPTH = tpa_pkg::DEF_RING_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tpa_pkg::CMD_W-1:0]     i_command,
    input  logic [tpa_pkg::PERIOD_W-1:0]  i_period_us,
    input  logic [tpa_pkg::TIME_W-1:0]    i_now_us,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tpa_pkg::RPM_W-1:0]     o_speed_rpm,
    output logic                          o_over_limit,
    output logic                          o_engine_running,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpa_pkg::ADDR_W-1:0]    paddr,
    input  logic [tpa_pkg::DATA_W-1:0]    pwdata,
    output logic [tpa_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import tpa_pkg::*;

    t_cfg w_cfg;
    t_ctl w_ctl;
    t_sts w_sts;

    tpa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_ctl       (w_ctl)
    );

    tpa_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_ctl            (w_ctl),
        .o_sts            (w_sts),
        .i_command        (i_command),
        .i_period_us      (i_period_us),
        .i_now_us         (i_now_us),
        .o_speed_rpm      (o_speed_rpm),
        .o_over_limit     (o_over_limit),
        .o_engine_running (o_engine_running)
    );

endmodule

[verif/tb_tachometer_period_averager.sv]
module tb_tachometer_period_averager;
    timeunit 1ns;
    timeprecision 1ps;

    import tpa_pkg::*;

    localparam int RING_DEPTH   = DEF_RING_DEPTH;
    localparam int QUIET_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 160;
    localparam int ITEMS_PER_SETTING = 84;

    // The block ignores this command; it is not part of the package enum.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [RPM_W-1:0] speed_rpm;
        logic             over_limit;
        logic             engine_running;
    } t_speed_result;

    class t_speed_scoreboard;
        logic [PERIOD_W-1:0]  period_store [RING_DEPTH];
        int unsigned          fill_count;
        int unsigned          next_slot;
        logic [TIME_W-1:0]    last_capture_us;
        logic [RPM_W-1:0]     rpm_now;
        logic [PPR_W-1:0]     ppr;
        logic [RPM_W-1:0]     limit_rpm;
        logic [RPM_W-1:0]     idle_rpm;
        logic [TIMEOUT_W-1:0] timeout_us;
        t_speed_result        pending [$];
        int errors;
        int results_checked;
        int captures, overflows, updates, unused_cmds, moving_updates;

        function new();
            fill_count      = 0;
            next_slot       = 0;
            last_capture_us = '0;
            rpm_now         = '0;
            ppr             = PPR_RESET;
            limit_rpm       = LIMIT_RESET;
            idle_rpm        = IDLE_RESET;
            timeout_us      = TIMEOUT_RESET;
            errors = 0;
            results_checked = 0;
            captures = 0;
            overflows = 0;
            updates = 0;
            unused_cmds = 0;
            moving_updates = 0;
        endfunction

        // Returns the value the register holds after the write.
        function logic [DATA_W-1:0] write_reg(t_reg_idx idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_PPR: begin
                    ppr = value[PPR_W-1:0];
                    return DATA_W'(ppr);
                end
                REG_LIMIT: begin
                    limit_rpm = value[RPM_W-1:0];
                    return DATA_W'(limit_rpm);
                end
                REG_IDLE: begin
                    idle_rpm = value[RPM_W-1:0];
                    return DATA_W'(idle_rpm);
                end
                default: begin
                    timeout_us = value[TIMEOUT_W-1:0];
                    return DATA_W'(timeout_us);
                end
            endcase
        endfunction

        function bit capture_fresh(logic [TIME_W-1:0] now_us);
            logic [TIME_W-1:0] elapsed;
            elapsed = now_us - last_capture_us;
            return elapsed < TIME_W'(timeout_us);
        endfunction

        function logic [RPM_W-1:0] averaged_rpm(logic [TIME_W-1:0] now_us);
            logic [63:0] sum;
            logic [63:0] mean;
            logic [63:0] quotient;
            if (fill_count == 0 || ppr == 0) return '0;
            sum = 0;
            for (int i = 0; i < fill_count; i++) sum += period_store[i];
            mean = sum / fill_count;
            if (mean <= MEAN_FLOOR_US || !capture_fresh(now_us)) return '0;
            quotient = 64'(US_PER_MINUTE) / (mean * ppr);
            return quotient[RPM_W-1:0];
        endfunction

        function void note_item(logic [CMD_W-1:0] cmd, logic [PERIOD_W-1:0] period_us,
                                logic [TIME_W-1:0] now_us);
            t_speed_result expected;
            case (cmd)
                CMD_CAPTURE: begin
                    if (fill_count < RING_DEPTH) fill_count++;
                    if (next_slot >= RING_DEPTH) next_slot = 0;
                    period_store[next_slot] = period_us;
                    next_slot++;
                    if (next_slot >= RING_DEPTH) next_slot = 0;
                    last_capture_us = now_us;
                    captures++;
                end
                CMD_OVERFLOW: begin
                    fill_count = 0;
                    next_slot  = 0;
                    overflows++;
                end
                CMD_UPDATE: begin
                    rpm_now = averaged_rpm(now_us);
                    updates++;
                    if (rpm_now != 0) moving_updates++;
                end
                default: unused_cmds++;
            endcase
            expected.speed_rpm      = rpm_now;
            expected.over_limit     = rpm_now > limit_rpm;
            expected.engine_running = capture_fresh(now_us) && (rpm_now > idle_rpm);
            pending.push_back(expected);
        endfunction

        function void check_result(logic [RPM_W-1:0] speed_rpm, logic over_limit,
                                   logic engine_running);
            t_speed_result expected;
            if (pending.size() == 0) begin
                $display("%0t: result item with none expected, speed_rpm %0d", $time,
                         speed_rpm);
                errors++;
                return;
            end
            expected = pending.pop_front();
            results_checked++;
            if (speed_rpm !== expected.speed_rpm) begin
                $display("%0t: speed_rpm expected %0d, got %0d", $time,
                         expected.speed_rpm, speed_rpm);
                errors++;
            end
            if (over_limit !== expected.over_limit) begin
                $display("%0t: over_limit expected %0b, got %0b", $time,
                         expected.over_limit, over_limit);
                errors++;
            end
            if (engine_running !== expected.engine_running) begin
                $display("%0t: engine_running expected %0b, got %0b", $time,
                         expected.engine_running, engine_running);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [CMD_W-1:0]    i_command = '0;
    logic [PERIOD_W-1:0] i_period_us = '0;
    logic [TIME_W-1:0]   i_now_us = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [RPM_W-1:0]    o_speed_rpm;
    logic                o_over_limit;
    logic                o_engine_running;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    tachometer_period_averager DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_period_us      (i_period_us),
        .i_now_us         (i_now_us),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_speed_rpm      (o_speed_rpm),
        .o_over_limit     (o_over_limit),
        .o_engine_running (o_engine_running),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    t_speed_scoreboard sb = new();

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          quiet_cycles = 0;
    int          reg_writes = 0;
    logic [TIME_W-1:0] clock_us = '0;

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_speed_rpm, o_over_limit, o_engine_running);
            if (i_in_valid && !o_in_stall)
                sb.note_item(i_command, i_period_us, i_now_us);
        end
        if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall) ||
            (psel && penable && pready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("[tachometer_period_averager] ERROR");
        $finish;
    end

    // Holds the item until it is accepted; the scoreboard sees it from the monitor.
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [PERIOD_W-1:0] period_us,
                             logic [TIME_W-1:0] now_us);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_period_us <= period_us;
        i_now_us    <= now_us;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic finish_phase();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic reg_write(t_reg_idx idx, logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] held;
        held = sb.write_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== held) begin
            $display("%0t: register %0d read expected 0x%0h, got 0x%0h", $time, idx, held,
                     prdata);
            sb.errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        reg_writes++;
    endtask

    task automatic apply_setting(int k);
        logic [DATA_W-1:0] ppr_val;
        logic [DATA_W-1:0] limit_val;
        logic [DATA_W-1:0] idle_val;
        logic [DATA_W-1:0] timeout_val;
        ppr_val     = $urandom_range(1, 12);
        limit_val   = $urandom_range(0, 120000);
        idle_val    = $urandom_range(0, 40000);
        timeout_val = $urandom_range(20000, 3000000);
        case (k)
            1: begin
                // All ones; each register keeps only its own width.
                ppr_val     = '1;
                limit_val   = '1;
                idle_val    = '1;
                timeout_val = '1;
            end
            2: begin
                ppr_val     = '0;
                timeout_val = '0;
            end
            4: begin
                ppr_val     = 1;
                limit_val   = 0;
                idle_val    = 0;
                timeout_val = 1;
            end
            6: begin
                ppr_val     = DATA_W'(PPR_RESET);
                limit_val   = DATA_W'(LIMIT_RESET);
                idle_val    = DATA_W'(IDLE_RESET);
                timeout_val = DATA_W'(TIMEOUT_RESET);
            end
            default: ;
        endcase
        reg_write(REG_PPR, ppr_val);
        reg_write(REG_LIMIT, limit_val);
        reg_write(REG_IDLE, idle_val);
        reg_write(REG_TIMEOUT, timeout_val);
    endtask

    task automatic edge_case_items();
        send_item(CMD_UPDATE, '0, 32'd0);
        send_item(CMD_CAPTURE, '0, 32'd0);
        send_item(CMD_UPDATE, '0, 32'd10);
        send_item(CMD_OVERFLOW, '1, 32'd20);
        send_item(CMD_CAPTURE, 22'd101, 32'd1000);
        send_item(CMD_UPDATE, '0, 32'd1050);
        // Mean of 101 and 100 sits exactly on the floor.
        send_item(CMD_CAPTURE, 22'd100, 32'd1100);
        send_item(CMD_UPDATE, '0, 32'd1300);
        send_item(CMD_CAPTURE, 22'd102, 32'd1400);
        send_item(CMD_UPDATE, '0, 32'd1500);
        send_item(CMD_CAPTURE, '1, 32'd2000);
        send_item(CMD_UPDATE, '0, 32'd2100);
        send_item(CMD_UNUSED, '1, '1);
        send_item(CMD_UPDATE, '0, 32'd2000 + TIME_W'(TIMEOUT_RESET) - 32'd1);
        send_item(CMD_UPDATE, '0, 32'd2000 + TIME_W'(TIMEOUT_RESET));
        send_item(CMD_OVERFLOW, '0, 32'd2000);
        send_item(CMD_CAPTURE, 22'd5000, 32'hFFFF_FFF0);
        send_item(CMD_UPDATE, '0, 32'h0000_0010);
        send_item(CMD_CAPTURE, 22'h2AAAAA, 32'h5555_5555);
        send_item(CMD_CAPTURE, 22'h155555, 32'hAAAA_AAAA);
        send_item(CMD_UPDATE, 22'h155555, 32'hAAAA_ABAA);
        send_item(CMD_UPDATE, '0, '1);
        send_item(CMD_OVERFLOW, '0, '1);
        send_item(CMD_UPDATE, '0, 32'd0);
        clock_us = 32'd10000;
    endtask

    // Mostly a plausible engine: time moves forward with each capture and updates
    // fall in between; the rest is overflows, wild periods, time jumps and junk.
    task automatic random_items(int count);
        int unsigned pick;
        logic [PERIOD_W-1:0] period_us;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            period_us = PERIOD_W'($urandom);
            if (pick < 55) begin
                if ($urandom_range(0, 9) < 8) period_us = PERIOD_W'($urandom_range(90, 30000));
                clock_us = clock_us + TIME_W'(period_us) + TIME_W'($urandom_range(0, 20));
                send_item(CMD_CAPTURE, period_us, clock_us);
            end else if (pick < 85) begin
                if ($urandom_range(0, 19) == 0)
                    clock_us = clock_us + TIME_W'($urandom);
                else
                    clock_us = clock_us + TIME_W'($urandom_range(0, 4000));
                send_item(CMD_UPDATE, period_us, clock_us);
            end else if (pick < 93) begin
                clock_us = clock_us + TIME_W'($urandom_range(0, 100));
                send_item(CMD_OVERFLOW, period_us, clock_us);
            end else begin
                send_item(CMD_UNUSED, period_us, TIME_W'($urandom));
            end
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 33;
        recv_stall_pct = 53;
        edge_case_items();
        finish_phase();

        for (int stage = 0; stage < 3; stage++) begin
            case (stage)
                0: begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 53;
                end
                1: begin
                    send_idle_pct  = 53;
                    recv_stall_pct = 33;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int sub = 0; sub < 3; sub++) begin
                apply_setting(stage * 3 + sub);
                random_items(ITEMS_PER_SETTING);
                finish_phase();
            end
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d captures, %0d overflows, %0d updates (%0d nonzero), %0d unused.",
                 sb.captures, sb.overflows, sb.updates, sb.moving_updates, sb.unused_cmds);
        $display("Checked %0d result items across %0d register writes, %0d mismatches.",
                 sb.results_checked, reg_writes, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("[tachometer_period_averager] OK");
        end else begin
            $display("[tachometer_period_averager] ERROR");
        end
        $finish;
    end

endmodule

[tachometer_period_averager.f]
src/tpa_pkg.sv
src/tpa_regs.sv
src/tpa_div.sv
src/tpa_datapath.sv
src/tpa_ctrl.sv
src/tachometer_period_averager.sv
verif/tb_tachometer_period_averager.sv
